/* rtl/core/mips_data_memory_access_unit_macros.svh */
// Assertion macros of the data memory access unit; the controller module includes them.
`ifndef MIPS_DATA_MEMORY_ACCESS_UNIT_MACROS_SVH
`define MIPS_DATA_MEMORY_ACCESS_UNIT_MACROS_SVH

// Checked property, disabled while reset is asserted.
`define MDMA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked property, evaluated at every clock edge including reset.
`define MDMA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/mdma_pkg.sv */
// Shared types, constants and helper functions of the data memory access unit.
`timescale 1ns / 1ps

package mdma_pkg;

    // Default memory depth in 32-bit words (1 KB).
    localparam int MEM_WORDS_DEFAULT = 256;

    // Access mode codes.
    localparam logic [2:0] MODE_LW  = 3'd0;
    localparam logic [2:0] MODE_LH  = 3'd1;
    localparam logic [2:0] MODE_LHU = 3'd2;
    localparam logic [2:0] MODE_LB  = 3'd3;
    localparam logic [2:0] MODE_LBU = 3'd4;
    localparam logic [2:0] MODE_SW  = 3'd5;
    localparam logic [2:0] MODE_SH  = 3'd6;
    localparam logic [2:0] MODE_SB  = 3'd7;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic cap;     // capture the incoming transaction
        logic clr;     // write zero at the clearing pointer and advance it
        logic commit;  // register the result and perform the store, if any
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;  // clearing pointer is at the last word
    } t_stat;

    // Alignment mask of an access: the low address bits that must be zero.
    // It is also the access size in bytes minus one.
    function automatic logic [1:0] access_mask(input logic [2:0] mode);
        logic [1:0] m;
        case (mode)
            MODE_LW, MODE_SW:          m = 2'b11;
            MODE_LH, MODE_LHU, MODE_SH: m = 2'b01;
            default:                   m = 2'b00;
        endcase
        return m;
    endfunction

    function automatic logic is_store(input logic [2:0] mode);
        return (mode == MODE_SW) || (mode == MODE_SH) || (mode == MODE_SB);
    endfunction

endpackage

/* rtl/core/mips_data_memory_access_unit.sv */
// Top level of the big-endian MIPS data memory access unit.
// A transaction accepted at one clock edge passes through a memory read state and an execute
// state; its result is registered onto o_valid when execute commits, which waits while an
// older result is still unconsumed. A new transaction is taken only after the current one
// leaves execute, as the registered read of the single memory port is followed by the merge
// and write-back through that same port. Reset (synchronous, active low) starts a clearing
// pass that zeroes the memory one word per cycle; o_ready stays low until it ends.
`timescale 1ns / 1ps

module mips_data_memory_access_unit #(
    // Memory depth in 32-bit words.
    parameter int MEM_WORDS = mdma_pkg::MEM_WORDS_DEFAULT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Request channel.
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [2:0]         i_mode,
    input  logic signed [31:0] i_address,
    input  logic [31:0]        i_store_data,
    // Result channel.
    output logic               o_valid,
    input  logic               i_ready,
    output logic [31:0]        o_load_data,
    output logic               o_overflow_error,
    output logic               o_misaligned_error
);

    // The controller sequences each transaction and owns the handshakes; the datapath
    // holds the word memory, the captured request and the result register. The result
    // register decouples the two channels, so a new transaction is taken while an older
    // result still waits for the consumer.
    mdma_pkg::t_cmd  cmd;
    mdma_pkg::t_stat stat;

    mdma_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // Errors suppress the memory write and force the loaded value to zero; stores
    // always return zero as their load data.
    mdma_dp #(
        .MEM_WORDS (MEM_WORDS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_stat             (stat),
        .i_mode             (i_mode),
        .i_address          (i_address),
        .i_store_data       (i_store_data),
        .o_load_data        (o_load_data),
        .o_overflow_error   (o_overflow_error),
        .o_misaligned_error (o_misaligned_error)
    );

endmodule

/* rtl/core/mdma_ctrl.sv */
// Controller state machine of the data memory access unit.
`timescale 1ns / 1ps
`include "mips_data_memory_access_unit_macros.svh"

module mdma_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    output logic             o_valid,
    input  logic             i_ready,
    input  mdma_pkg::t_stat  i_stat,
    output mdma_pkg::t_cmd   o_cmd
);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_READ  = 2'd2;
    localparam logic [1:0] S_EXEC  = 2'd3;

    logic [1:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       out_free;

    // The result register can take a new value when empty or drained this cycle.
    assign out_free = !r_out_valid || i_ready;

    always_comb begin
        o_cmd.cap    = (r_state == S_IDLE) && i_valid;
        o_cmd.clr    = (r_state == S_CLEAR);
        o_cmd.commit = (r_state == S_EXEC) && out_free;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_valid;

    `MDMA_ASSERT(a_item_flow, i_clk, i_rst_n, o_cmd.cap |=> (r_state == S_READ) ##1 (r_state == S_EXEC), "accepted transaction did not advance through read and execute")
    `MDMA_ASSERT(a_result_source, i_clk, i_rst_n, $rose(r_out_valid) |-> ($past(r_state) == S_EXEC), "result appeared without an executed transaction")
    `MDMA_ASSERT_ALWAYS(a_no_result_in_clear, i_clk, (r_state == S_CLEAR) |-> !r_out_valid, "result pending during the clearing pass")

endmodule

/* rtl/core/mdma_dp.sv */
// Datapath of the data memory access unit: word memory, checks, load and merge.
`timescale 1ns / 1ps

module mdma_dp #(
    parameter int MEM_WORDS = mdma_pkg::MEM_WORDS_DEFAULT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mdma_pkg::t_cmd      i_cmd,
    output mdma_pkg::t_stat     o_stat,
    input  logic [2:0]          i_mode,
    input  logic signed [31:0]  i_address,
    input  logic [31:0]         i_store_data,
    output logic [31:0]         o_load_data,
    output logic                o_overflow_error,
    output logic                o_misaligned_error
);

    localparam int          IDX_W     = $clog2(MEM_WORDS);
    localparam logic [31:0] MEM_BYTES = 32'(MEM_WORDS * 4);

    logic [31:0]      r_mem [MEM_WORDS];
    logic [2:0]       r_mode;
    logic [31:0]      r_addr;
    logic [31:0]      r_sdata;
    logic [31:0]      r_rdata;
    logic [IDX_W-1:0] r_clr_idx, n_clr_idx;
    logic [31:0]      r_load_data;
    logic             r_ovf;
    logic             r_mis;

    logic [1:0]       mask;
    logic [31:0]      limit;
    logic             ovf;
    logic             mis;
    logic             ok;
    logic [IDX_W-1:0] idx;
    logic [1:0]       off;
    logic [15:0]      half;
    logic [7:0]       byte_v;
    logic [31:0]      load_val;
    logic [31:0]      merged;
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [31:0]      wdata;

    // Range and alignment checks on the captured address.
    assign mask  = mdma_pkg::access_mask(r_mode);
    assign limit = MEM_BYTES - {30'd0, mask} - 32'd1;
    assign ovf   = r_addr[31] || (r_addr > limit);
    assign mis   = (r_addr[1:0] & mask) != 2'b00;
    assign ok    = !ovf && !mis;

    assign idx  = r_addr[IDX_W+1:2];
    assign off  = r_addr[1:0];
    assign half = off[1] ? r_rdata[15:0] : r_rdata[31:16];

    // Big-endian byte lanes: offset 0 is the most significant byte.
    always_comb begin
        case (off)
            2'd0:    byte_v = r_rdata[31:24];
            2'd1:    byte_v = r_rdata[23:16];
            2'd2:    byte_v = r_rdata[15:8];
            default: byte_v = r_rdata[7:0];
        endcase
    end

    always_comb begin
        case (r_mode)
            mdma_pkg::MODE_LW:  load_val = r_rdata;
            mdma_pkg::MODE_LH:  load_val = {{16{half[15]}}, half};
            mdma_pkg::MODE_LHU: load_val = {16'd0, half};
            mdma_pkg::MODE_LB:  load_val = {{24{byte_v[7]}}, byte_v};
            mdma_pkg::MODE_LBU: load_val = {24'd0, byte_v};
            default:            load_val = 32'd0;
        endcase
    end

    // Store merge into the word read from memory.
    always_comb begin
        merged = r_rdata;
        case (r_mode)
            mdma_pkg::MODE_SW: begin
                merged = r_sdata;
            end
            mdma_pkg::MODE_SH: begin
                if (off[1]) begin
                    merged[15:0] = r_sdata[15:0];
                end else begin
                    merged[31:16] = r_sdata[15:0];
                end
            end
            mdma_pkg::MODE_SB: begin
                case (off)
                    2'd0:    merged[31:24] = r_sdata[7:0];
                    2'd1:    merged[23:16] = r_sdata[7:0];
                    2'd2:    merged[15:8]  = r_sdata[7:0];
                    default: merged[7:0]   = r_sdata[7:0];
                endcase
            end
            default: begin
                merged = r_rdata;
            end
        endcase
    end

    // Single write port, shared by the clearing pass and stores.
    assign we    = i_cmd.clr || (i_cmd.commit && ok && mdma_pkg::is_store(r_mode));
    assign waddr = i_cmd.clr ? r_clr_idx : idx;
    assign wdata = i_cmd.clr ? 32'd0 : merged;

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        r_rdata <= r_mem[idx];
    end

    assign n_clr_idx     = i_cmd.clr ? r_clr_idx + 1'b1 : r_clr_idx;
    assign o_stat.clr_last = (r_clr_idx == IDX_W'(MEM_WORDS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx <= '0;
        end else begin
            r_clr_idx <= n_clr_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_mode  <= i_mode;
            r_addr  <= i_address;
            r_sdata <= i_store_data;
        end
        if (i_cmd.commit) begin
            r_load_data <= ok ? load_val : 32'd0;
            r_ovf       <= ovf;
            r_mis       <= mis;
        end
    end

    assign o_load_data        = r_load_data;
    assign o_overflow_error   = r_ovf;
    assign o_misaligned_error = r_mis;

endmodule

/* test/tb.sv */
// Testbench for the data memory access unit: random and directed loads and stores checked against a model.
`timescale 1ns / 1ps

// Models the memory of the unit and keeps the results that are still owed.
class load_store_scoreboard;

    typedef struct packed {
        logic [31:0] load_data;
        logic        overflow;
        logic        misaligned;
    } t_access_result;

    logic [31:0]    words [mdma_pkg::MEM_WORDS_DEFAULT];
    t_access_result pending_results [$];
    int unsigned    mismatches;
    int unsigned    results_checked;
    int unsigned    loads_seen;
    int unsigned    stores_seen;
    int unsigned    flagged_seen;

    function new();
        foreach (words[k]) words[k] = '0;
        mismatches      = 0;
        results_checked = 0;
        loads_seen      = 0;
        stores_seen     = 0;
        flagged_seen    = 0;
    endfunction

    static function int unsigned access_bytes(input logic [2:0] mode);
        case (mode)
            mdma_pkg::MODE_LW, mdma_pkg::MODE_SW:                    return 4;
            mdma_pkg::MODE_LH, mdma_pkg::MODE_LHU, mdma_pkg::MODE_SH: return 2;
            default:                                                 return 1;
        endcase
    endfunction

    // Works out the result of one accepted transaction and applies any store.
    function void note_access(input logic [2:0] mode, input logic [31:0] addr,
                              input logic [31:0] wdata);
        t_access_result r;
        int unsigned    bytes;
        int unsigned    idx;
        int unsigned    hsh;
        int unsigned    bsh;
        logic [31:0]    word;
        bytes        = access_bytes(mode);
        r.load_data  = '0;
        r.overflow   = addr[31] || (addr > mdma_pkg::MEM_WORDS_DEFAULT * 4 - bytes);
        r.misaligned = (addr & (bytes - 1)) != 0;
        if (mode == mdma_pkg::MODE_SW || mode == mdma_pkg::MODE_SH
            || mode == mdma_pkg::MODE_SB) begin
            stores_seen++;
        end else begin
            loads_seen++;
        end
        if (r.overflow || r.misaligned) begin
            flagged_seen++;
        end else begin
            // Big-endian: offset 0 is the most significant byte of the word.
            idx  = addr[31:2];
            word = words[idx];
            hsh  = addr[1] ? 0 : 16;
            bsh  = 8 * (3 - int'(addr[1:0]));
            case (mode)
                mdma_pkg::MODE_LW:  r.load_data = word;
                mdma_pkg::MODE_LH:  r.load_data = {{16{word[hsh + 15]}}, word[hsh +: 16]};
                mdma_pkg::MODE_LHU: r.load_data = {16'd0, word[hsh +: 16]};
                mdma_pkg::MODE_LB:  r.load_data = {{24{word[bsh + 7]}}, word[bsh +: 8]};
                mdma_pkg::MODE_LBU: r.load_data = {24'd0, word[bsh +: 8]};
                mdma_pkg::MODE_SW:  words[idx] = wdata;
                mdma_pkg::MODE_SH:  words[idx][hsh +: 16] = wdata[15:0];
                default:            words[idx][bsh +: 8] = wdata[7:0];
            endcase
        end
        pending_results.push_back(r);
    endfunction

    // Compares one accepted result with the oldest one still owed.
    function void check_result(input logic [31:0] load_data, input logic overflow,
                               input logic misaligned);
        t_access_result want;
        if (pending_results.size() == 0) begin
            $display("%0t: result with nothing owed: load_data %h ovf %b mis %b",
                     $time, load_data, overflow, misaligned);
            mismatches++;
            return;
        end
        want = pending_results.pop_front();
        results_checked++;
        if (load_data !== want.load_data) begin
            $display("%0t: load_data expected %h actual %h", $time, want.load_data, load_data);
            mismatches++;
        end
        if (overflow !== want.overflow) begin
            $display("%0t: overflow_error expected %b actual %b", $time, want.overflow,
                     overflow);
            mismatches++;
        end
        if (misaligned !== want.misaligned) begin
            $display("%0t: misaligned_error expected %b actual %b", $time, want.misaligned,
                     misaligned);
            mismatches++;
        end
    endfunction

endclass

module tb;

    localparam int CYCLE_LIMIT        = 200000;
    localparam int LONG_STALL_CYCLES  = 300;
    localparam int ITEMS_PER_PHASE    = 420;
    localparam int DRAIN_CYCLES       = 10;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic [2:0]         i_mode = mdma_pkg::MODE_LW;
    logic signed [31:0] i_address = '0;
    logic [31:0]        i_store_data = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic [31:0]        o_load_data;
    logic               o_overflow_error;
    logic               o_misaligned_error;

    // Pacing knobs, in percent of cycles spent idle on each side.
    int unsigned sender_idle_pct   = 0;
    int unsigned receiver_idle_pct = 0;
    // The result side holds off once for a long stretch after this goes high.
    logic        long_stall_armed  = 1'b0;
    int unsigned long_stall_count  = 0;
    int unsigned cycle_count       = 0;

    load_store_scoreboard sb;

    mips_data_memory_access_unit u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_mode             (i_mode),
        .i_address          (i_address),
        .i_store_data       (i_store_data),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_load_data        (o_load_data),
        .o_overflow_error   (o_overflow_error),
        .o_misaligned_error (o_misaligned_error)
    );

    always #1 i_clk = ~i_clk;

    // Watchdog: a hang anywhere ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("Test completed with failures");
            $finish;
        end
    end

    // Both handshakes are sampled at the rising edge, before the unit updates.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                sb.note_access(i_mode, i_address, i_store_data);
            end
            if (o_valid && i_ready) begin
                sb.check_result(o_load_data, o_overflow_error, o_misaligned_error);
            end
        end
    end

    // Result side: random stalls, plus one long hold-off that fills the unit up so that
    // it has to push back on its request side.
    always @(negedge i_clk) begin
        if (long_stall_armed && long_stall_count < LONG_STALL_CYCLES) begin
            long_stall_count <= long_stall_count + 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    // Number of idle cycles before the next request, geometric in the idle percentage.
    function automatic int unsigned sender_gap();
        int unsigned n;
        n = 0;
        while ($urandom_range(99) < sender_idle_pct && n < 20) n++;
        return n;
    endfunction

    // Offers one transaction and returns at the falling edge after it was taken.
    task automatic send_access(input logic [2:0] mode, input logic [31:0] addr,
                               input logic [31:0] wdata);
        int unsigned gap;
        gap = sender_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_mode       <= mode;
        i_address    <= addr;
        i_store_data <= wdata;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
    endtask

    // Mostly legal accesses, many in a small window so loads see earlier stores;
    // the rest are misaligned, run off the top of memory, or use any address at all.
    task automatic send_random_access();
        logic [2:0]  mode;
        logic [31:0] addr;
        int unsigned bytes;
        int unsigned kind;
        mode  = $urandom_range(7);
        bytes = sb.access_bytes(mode);
        kind  = $urandom_range(99);
        if (kind < 80) begin
            addr = $urandom_range(1) ? $urandom_range(63) : $urandom_range(1023);
            addr = addr & ~(bytes - 1);
        end else if (kind < 88) begin
            addr = $urandom_range(1023);
        end else if (kind < 94) begin
            addr = 1016 + $urandom_range(15);
        end else begin
            addr = $urandom;
        end
        send_access(mode, addr, $urandom);
    endtask

    // Lowers the request and waits until every owed result has come back.
    task automatic wait_for_drain();
        i_valid <= 1'b0;
        do @(negedge i_clk); while (sb.pending_results.size() != 0);
    endtask

    initial begin
        sb = new();
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, paced as in the first random phase.
        sender_idle_pct   = 34;
        receiver_idle_pct = 45;
        send_access(mdma_pkg::MODE_LW,  32'd0,    32'h0);           // cleared memory
        send_access(mdma_pkg::MODE_LW,  32'd1020, 32'h0);           // last word, cleared
        send_access(mdma_pkg::MODE_SW,  32'd0,    32'h80017FFF);
        send_access(mdma_pkg::MODE_LW,  32'd0,    32'h0);
        send_access(mdma_pkg::MODE_LH,  32'd0,    32'h0);           // negative upper half
        send_access(mdma_pkg::MODE_LH,  32'd2,    32'h0);           // positive lower half
        send_access(mdma_pkg::MODE_LHU, 32'd0,    32'h0);
        send_access(mdma_pkg::MODE_LB,  32'd0,    32'h0);
        send_access(mdma_pkg::MODE_LBU, 32'd0,    32'h0);
        send_access(mdma_pkg::MODE_LB,  32'd3,    32'h0);
        send_access(mdma_pkg::MODE_SW,  32'd1020, 32'hFFFFFFFF);
        send_access(mdma_pkg::MODE_SH,  32'd1022, 32'h123400A5);   // highest halfword
        send_access(mdma_pkg::MODE_SB,  32'd1023, 32'hFFFFFF5A);   // highest byte
        send_access(mdma_pkg::MODE_SB,  32'd1021, 32'h00000000);
        send_access(mdma_pkg::MODE_LW,  32'd1020, 32'h0);
        send_access(mdma_pkg::MODE_LBU, 32'd1023, 32'h0);
        // Error cases: none of these may touch memory.
        send_access(mdma_pkg::MODE_LW,  32'd1024, 32'h0);           // just past the end
        send_access(mdma_pkg::MODE_LH,  32'd1023, 32'h0);           // both flags
        send_access(mdma_pkg::MODE_SW,  32'd1022, 32'hDEADBEEF);   // both flags on a store
        send_access(mdma_pkg::MODE_SH,  32'd1,    32'hFFFFFFFF);   // misaligned only
        send_access(mdma_pkg::MODE_SW,  32'd2,    32'hFFFFFFFF);
        send_access(mdma_pkg::MODE_LW,  32'h80000000, 32'h0);       // most negative address
        send_access(mdma_pkg::MODE_SB,  32'h80000001, 32'hFFFFFFFF); // negative byte store
        send_access(mdma_pkg::MODE_LH,  32'hFFFFFFFF, 32'h0);       // negative and misaligned
        send_access(mdma_pkg::MODE_LW,  32'h7FFFFFFC, 32'h0);       // largest positive word
        send_access(mdma_pkg::MODE_LW,  32'd0,    32'h0);           // still unchanged
        wait_for_drain();

        // Phase one: sender idles less than the receiver.
        repeat (ITEMS_PER_PHASE) send_random_access();
        wait_for_drain();

        // Phase two: the other way round.
        sender_idle_pct   = 45;
        receiver_idle_pct = 34;
        repeat (ITEMS_PER_PHASE) send_random_access();
        wait_for_drain();

        // Phase three: full rate on both sides, with one long hold-off on results early on.
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        repeat (20) send_random_access();
        long_stall_armed <= 1'b1;
        repeat (ITEMS_PER_PHASE - 20) send_random_access();
        wait_for_drain();
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Ran %0d loads and %0d stores, %0d of them flagged as out of range or misaligned,",
                 sb.loads_seen, sb.stores_seen, sb.flagged_seen);
        $display("under two uneven pacing mixes, full rate, and one %0d-cycle result stall.",
                 LONG_STALL_CYCLES);
        if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/mdma_pkg.sv
rtl/core/mdma_ctrl.sv
rtl/core/mdma_dp.sv
rtl/core/mips_data_memory_access_unit.sv
test/tb.sv
